// File: sv/convex_polygon_line_clipper_assert.svh
// Assertion macros for the line clipper checker.
// Needs a clock named clock and a reset named reset in the using scope.
`ifndef CONVEX_POLYGON_LINE_CLIPPER_ASSERT_SVH
`define CONVEX_POLYGON_LINE_CLIPPER_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define CCL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("line clipper check failed: next-cycle rule");

// Consequent must hold in the same cycle as the antecedent.
`define CCL_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("line clipper check failed: same-cycle rule");

`endif

// File: sv/ccl_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the convex polygon line clipper.
// No dependencies.
package ccl_pkg;

   localparam int FRAC_BITS = 30;                         // t is unsigned Q1.30
   localparam logic [FRAC_BITS:0] T_ONE  = 31'h4000_0000; // 1.0
   localparam logic [FRAC_BITS:0] T_ZERO = '0;            // 0.0

   localparam int VC_BITS = 5;
   localparam logic [VC_BITS-1:0] VC_RESET = 5'd4;
   localparam logic [VC_BITS-1:0] VC_MIN   = 5'd3;

   localparam logic REG_VERTEX_COUNT = 1'b0;

   typedef enum logic {
      KIND_VERTEX = 1'b0,
      KIND_CLIP   = 1'b1
   } kind_type;

endpackage

// File: sv/ccl_req_if.sv
`timescale 1ns / 1ps
// Request channel of the line clipper: vertex writes and clip items.
// Stand-alone; width follows COORD_BITS.
interface ccl_req_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic [3:0]                   vertex_index;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;

   modport source (output valid, kind, vertex_index, start_x, start_y, end_x, end_y,
                   input ready);
   modport sink   (input valid, kind, vertex_index, start_x, start_y, end_x, end_y,
                   output ready);
endinterface

// File: sv/ccl_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the line clipper: visibility and clipped endpoints.
// Stand-alone; width follows COORD_BITS.
interface ccl_rsp_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic                         visible;
   logic signed [COORD_BITS-1:0] clip_start_x;
   logic signed [COORD_BITS-1:0] clip_start_y;
   logic signed [COORD_BITS-1:0] clip_end_x;
   logic signed [COORD_BITS-1:0] clip_end_y;

   modport source (output valid, visible, clip_start_x, clip_start_y, clip_end_x,
                   clip_end_y, input ready);
   modport sink   (input valid, visible, clip_start_x, clip_start_y, clip_end_x,
                   clip_end_y, output ready);
endinterface

// File: sv/ccl_queue.sv
`timescale 1ns / 1ps
// Two-entry FIFO between the clipper front and back.
// Stand-alone; entry width is a parameter.
module ccl_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

// File: sv/ccl_front.sv
`timescale 1ns / 1ps
// Clipper front: accepts request items, drops vertex writes beyond the table,
// forms the segment deltas and edge count, and hands entries to the queue. Uses ccl_pkg.
module ccl_front #(
   parameter int MAX_VERTICES = 16,
   parameter int COORD_BITS   = 16,
   parameter int NW           = 5,
   parameter int EW           = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   ccl_req_if.sink                       req,
   input  logic [ccl_pkg::VC_BITS-1:0]   vertex_count,
   output logic                          ent_valid,
   input  logic                          ent_ready,
   output logic [EW-1:0]                 ent_data
);
   import ccl_pkg::*;

   logic            ent_valid_ff;
   logic [EW-1:0]   ent_ff;
   logic            req_ok;
   logic            keep;
   logic [NW-1:0]   n_edges;
   logic signed [COORD_BITS:0] dx;
   logic signed [COORD_BITS:0] dy;

   assign req.ready = !ent_valid_ff || ent_ready;
   assign req_ok    = req.valid && req.ready;
   assign ent_valid = ent_valid_ff;
   assign ent_data  = ent_ff;

   assign keep = (kind_type'(req.kind) == KIND_CLIP)
              || (8'(req.vertex_index) < 8'(MAX_VERTICES));

   assign dx = (COORD_BITS+1)'(req.end_x) - (COORD_BITS+1)'(req.start_x);
   assign dy = (COORD_BITS+1)'(req.end_y) - (COORD_BITS+1)'(req.start_y);

   // clamp the corner count into [3, MAX_VERTICES]
   always_comb begin
      if (vertex_count < VC_MIN) begin
         n_edges = NW'(VC_MIN);
      end else if (8'(vertex_count) > 8'(MAX_VERTICES)) begin
         n_edges = NW'(MAX_VERTICES);
      end else begin
         n_edges = NW'(vertex_count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
      end else if (req_ok) begin
         ent_valid_ff <= keep;
         ent_ff <= {req.kind, req.vertex_index, req.start_x, req.start_y, dx, dy, n_edges};
      end else if (ent_ready) begin
         ent_valid_ff <= 1'b0;
      end
   end

endmodule

// File: sv/ccl_back.sv
`timescale 1ns / 1ps
// Clipper back: corner table, per-edge cross products, shared bit-serial
// divider, bound tracking, endpoint scaling and the result register. Uses ccl_pkg.
module ccl_back #(
   parameter int MAX_VERTICES = 16,
   parameter int COORD_BITS   = 16,
   parameter int NW           = 5,
   parameter int EW           = 8
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           ent_valid,
   output logic           ent_ready,
   input  logic [EW-1:0]  ent_data,
   ccl_rsp_if.source      rsp
);
   import ccl_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int IW = $clog2(MAX_VERTICES);
   localparam int PW = 2 * CB + 2;
   localparam int SW = 2 * CB + 3;
   localparam int XW = (SW > 64) ? 64 : SW;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_MUL, S_SUB, S_DEC, S_DIV, S_UPD, S_NEXT, S_SMUL, S_SADD, S_FIN
   } state_type;

   state_type state_ff;

   logic signed [CB-1:0] cx_mem_ff [MAX_VERTICES];
   logic signed [CB-1:0] cy_mem_ff [MAX_VERTICES];

   logic signed [CB-1:0] cxi_ff, cyi_ff, cxj_ff, cyj_ff;
   logic signed [CB-1:0] x1_ff, y1_ff;
   logic signed [CB:0]   dx_ff, dy_ff;
   logic [NW-1:0]        n_ff;
   logic [IW-1:0]        i_ff;
   logic [IW-1:0]        j_idx;
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic [XW-1:0]        den_ff, wt_ff, d_ff;
   logic [XW:0]          r_ff;
   logic [4:0]           cnt_ff;
   logic                 enter_ff;
   logic [FRAC_BITS:0]   tq_ff, tl_ff, tu_ff;
   logic [1:0]           k_ff;
   logic [CB+31:0]       prod_ff;
   logic                 vis_ff;
   logic [CB-1:0]        res_ff [4];
   logic                 rsp_valid_ff;
   logic                 rsp_vis_ff;
   logic [CB-1:0]        rsp_res_ff [4];

   // unpacked queue entry
   logic                 e_kind;
   logic [3:0]           e_idx;
   logic signed [CB-1:0] e_x1, e_y1;
   logic signed [CB:0]   e_dx, e_dy;
   logic [NW-1:0]        e_n;

   logic signed [CB:0]   ex, ey, ax, ay;
   logic signed [SW-1:0] den_full, wt_full;
   logic [XW-1:0]        den_mag, wt_mag;
   logic [XW:0]          r_shift;
   logic [FRAC_BITS:0]   tl_new, tu_new;
   logic signed [CB:0]   s_delta;
   logic [CB:0]          s_mag;
   logic [FRAC_BITS:0]   s_t;
   logic [CB-1:0]        s_base, s_p, s_res;
   logic                 fin_send;

   assign {e_kind, e_idx, e_x1, e_y1, e_dx, e_dy, e_n} = ent_data;
   assign ent_ready = (state_ff == S_IDLE);

   assign j_idx = ((NW'(i_ff) + 1'b1) == n_ff) ? '0 : IW'(i_ff + 1'b1);

   assign ex = (CB+1)'(cxj_ff) - (CB+1)'(cxi_ff);
   assign ey = (CB+1)'(cyj_ff) - (CB+1)'(cyi_ff);
   assign ax = (CB+1)'(x1_ff)  - (CB+1)'(cxi_ff);
   assign ay = (CB+1)'(y1_ff)  - (CB+1)'(cyi_ff);

   assign den_full = SW'(p0_ff) - SW'(p1_ff);
   assign wt_full  = SW'(p2_ff) - SW'(p3_ff);
   assign den_mag  = den_ff[XW-1] ? (~den_ff + 1'b1) : den_ff;
   assign wt_mag   = wt_ff[XW-1]  ? (~wt_ff + 1'b1)  : wt_ff;
   assign r_shift  = {r_ff[XW-1:0], 1'b0};

   assign tl_new = (enter_ff && (tq_ff > tl_ff)) ? tq_ff : tl_ff;
   assign tu_new = (!enter_ff && (tq_ff < tu_ff)) ? tq_ff : tu_ff;

   // endpoint scaling: k[0] picks the axis, k[1] picks the bound
   assign s_delta = k_ff[0] ? dy_ff : dx_ff;
   assign s_mag   = s_delta[CB] ? (~s_delta + 1'b1) : s_delta;
   assign s_t     = k_ff[1] ? tu_ff : tl_ff;
   assign s_base  = k_ff[0] ? y1_ff : x1_ff;
   assign s_p     = prod_ff[FRAC_BITS +: CB];
   assign s_res   = s_delta[CB] ? (s_base - s_p) : (s_base + s_p);

   // finished item moves into the result register when it is free
   assign fin_send = (state_ff == S_FIN) && (!rsp_valid_ff || rsp.ready);

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.visible      = rsp_vis_ff;
   assign rsp.clip_start_x = rsp_res_ff[0];
   assign rsp.clip_start_y = rsp_res_ff[1];
   assign rsp.clip_end_x   = rsp_res_ff[2];
   assign rsp.clip_end_y   = rsp_res_ff[3];

   // corner table: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && ent_valid && kind_type'(e_kind) == KIND_VERTEX) begin
         cx_mem_ff[IW'(e_idx)] <= e_x1;
         cy_mem_ff[IW'(e_idx)] <= e_y1;
      end
      if (state_ff == S_READ) begin
         cxi_ff <= cx_mem_ff[i_ff];
         cyi_ff <= cy_mem_ff[i_ff];
         cxj_ff <= cx_mem_ff[j_idx];
         cyj_ff <= cy_mem_ff[j_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fin_send) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (ent_valid && kind_type'(e_kind) == KIND_CLIP) begin
                  x1_ff    <= e_x1;
                  y1_ff    <= e_y1;
                  dx_ff    <= e_dx;
                  dy_ff    <= e_dy;
                  n_ff     <= e_n;
                  i_ff     <= '0;
                  tl_ff    <= T_ZERO;
                  tu_ff    <= T_ONE;
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_MUL;
            S_MUL: begin
               p0_ff    <= PW'(ex) * PW'(dy_ff);
               p1_ff    <= PW'(ey) * PW'(dx_ff);
               p2_ff    <= PW'(ex) * PW'(ay);
               p3_ff    <= PW'(ey) * PW'(ax);
               state_ff <= S_SUB;
            end
            S_SUB: begin
               den_ff   <= den_full[XW-1:0];
               wt_ff    <= wt_full[XW-1:0];
               state_ff <= S_DEC;
            end
            S_DEC: begin
               tq_ff  <= T_ZERO;
               cnt_ff <= '0;
               d_ff   <= den_mag;
               if (den_ff == '0) begin
                  // parallel edge: outside drops the segment, otherwise skip
                  state_ff <= wt_ff[XW-1] ? S_FIN : S_NEXT;
                  vis_ff   <= 1'b0;
                  res_ff   <= '{default: '0};
               end else if (!den_ff[XW-1]) begin
                  enter_ff <= 1'b1;
                  r_ff     <= {1'b0, wt_mag};
                  if (!wt_ff[XW-1]) begin
                     state_ff <= S_NEXT;
                  end else if (wt_mag > den_ff) begin
                     state_ff <= S_FIN;
                     vis_ff   <= 1'b0;
                     res_ff   <= '{default: '0};
                  end else if (wt_mag == den_ff) begin
                     tq_ff    <= T_ONE;
                     state_ff <= S_UPD;
                  end else begin
                     state_ff <= S_DIV;
                  end
               end else begin
                  enter_ff <= 1'b0;
                  r_ff     <= {1'b0, wt_ff};
                  if (wt_ff[XW-1]) begin
                     state_ff <= S_FIN;
                     vis_ff   <= 1'b0;
                     res_ff   <= '{default: '0};
                  end else if (wt_ff < den_mag) begin
                     state_ff <= S_DIV;
                  end else begin
                     state_ff <= S_NEXT;
                  end
               end
            end
            S_DIV: begin
               // one quotient bit per cycle, restoring
               if (r_shift >= {1'b0, d_ff}) begin
                  r_ff  <= r_shift - {1'b0, d_ff};
                  tq_ff <= {tq_ff[FRAC_BITS-1:0], 1'b1};
               end else begin
                  r_ff  <= r_shift;
                  tq_ff <= {tq_ff[FRAC_BITS-1:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 5'(FRAC_BITS - 1)) begin
                  state_ff <= S_UPD;
               end
            end
            S_UPD: begin
               if (tl_new > tu_new) begin
                  state_ff <= S_FIN;
                  vis_ff   <= 1'b0;
                  res_ff   <= '{default: '0};
               end else begin
                  tl_ff    <= tl_new;
                  tu_ff    <= tu_new;
                  state_ff <= S_NEXT;
               end
            end
            S_NEXT: begin
               if ((NW'(i_ff) + 1'b1) == n_ff) begin
                  k_ff     <= '0;
                  vis_ff   <= 1'b1;
                  state_ff <= S_SMUL;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_READ;
               end
            end
            S_SMUL: begin
               prod_ff  <= (CB+32)'(s_mag) * (CB+32)'(s_t);
               state_ff <= S_SADD;
            end
            S_SADD: begin
               res_ff[k_ff] <= s_res;
               k_ff         <= k_ff + 1'b1;
               state_ff     <= (k_ff == 2'd3) ? S_FIN : S_SMUL;
            end
            S_FIN: begin
               // hold until the result register is free
               if (fin_send) begin
                  rsp_vis_ff <= vis_ff;
                  rsp_res_ff <= res_ff;
                  state_ff   <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: sv/convex_polygon_line_clipper.sv
`timescale 1ns / 1ps
// Cyrus-Beck line clipper. Vertex writes: one per cycle while the back is idle. A clip
// result is registered once the back has walked every edge (read, multiply, subtract,
// decide, divide where needed, update) and scaled the endpoints, or earlier when an edge
// rejects the segment; one clip at a time in the back, with the shared one-bit-per-cycle divider.
// Synchronous active-high reset clears control state and sets vertex_count to 4;
// the corner table is not cleared and reads undefined until written.
// Uses ccl_pkg, ccl_req_if, ccl_rsp_if, ccl_front, ccl_queue, ccl_back.
module convex_polygon_line_clipper #(
   parameter int MAX_VERTICES = 16,
   parameter int COORD_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   ccl_req_if.sink     req,
   ccl_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ccl_pkg::*;

   // edge count holds up to MAX_VERTICES; queue entry carries kind, slot,
   // start point, deltas and the clamped edge count
   localparam int NW = $clog2(MAX_VERTICES + 1);
   localparam int EW = 1 + 4 + 2 * COORD_BITS + 2 * (COORD_BITS + 1) + NW;

   logic [VC_BITS-1:0] vertex_count_ff;
   logic               csr_sel_vc;

   logic          f_valid, f_ready;
   logic [EW-1:0] f_data;
   logic          b_valid, b_ready;
   logic [EW-1:0] b_data;

   // register file: a single register, selected whenever paddr[2] is low (offsets 0 to 3)
   assign csr_pready = 1'b1;
   assign csr_sel_vc = (csr_paddr[2] == REG_VERTEX_COUNT);
   assign csr_prdata = csr_sel_vc ? 32'(vertex_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VC_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_vc) begin
         vertex_count_ff <= csr_pwdata[VC_BITS-1:0];
      end
   end

   // front: accept, drop out-of-table vertex writes, form deltas
   ccl_front #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS),
      .NW           (NW),
      .EW           (EW)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .vertex_count (vertex_count_ff),
      .ent_valid    (f_valid),
      .ent_ready    (f_ready),
      .ent_data     (f_data)
   );

   // decouple so vertex writes keep flowing while the back walks edges, until the queue fills
   ccl_queue #(
      .WIDTH (EW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (b_data)
   );

   // back: table, edge walk, divide, scale, result register
   ccl_back #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS),
      .NW           (NW),
      .EW           (EW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .ent_valid (b_valid),
      .ent_ready (b_ready),
      .ent_data  (b_data),
      .rsp       (rsp)
   );

endmodule

// File: sv/ccl_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the line clipper, bound to the top level.
// Depends on convex_polygon_line_clipper_assert.svh.
`include "convex_polygon_line_clipper_assert.svh"

module ccl_checker #(
   parameter int COORD_BITS = 16
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_visible,
   input logic [COORD_BITS-1:0] clip_start_x,
   input logic [COORD_BITS-1:0] clip_start_y,
   input logic [COORD_BITS-1:0] clip_end_x,
   input logic [COORD_BITS-1:0] clip_end_y
);

   `CCL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `CCL_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_visible) && $stable(clip_start_x) && $stable(clip_start_y) && $stable(clip_end_x) && $stable(clip_end_y))
   `CCL_ASSERT_SAME(a_reject_zero, rsp_valid && !rsp_visible, clip_start_x == '0 && clip_start_y == '0 && clip_end_x == '0 && clip_end_y == '0)
   `CCL_ASSERT_SAME(a_reset_empty, $past(reset), !rsp_valid)

endmodule

bind convex_polygon_line_clipper ccl_checker #(
   .COORD_BITS (COORD_BITS)
) u_ccl_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_visible  (rsp.visible),
   .clip_start_x (rsp.clip_start_x),
   .clip_start_y (rsp.clip_start_y),
   .clip_end_x   (rsp.clip_end_x),
   .clip_end_y   (rsp.clip_end_y)
);
